// ----- hdl/fmbf_pkg.sv -----
// Shared types, codes and constants for the FLAC metadata block filter.
`default_nettype none
package fmbf_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ROUTE_W  = 2;
  localparam int unsigned TYPE_W   = 7;
  localparam int unsigned ERR_W    = 2;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 2;
  localparam int unsigned LEN_W    = 24;
  localparam int unsigned TUSER_W  = 16;

  // Default depth of the queue between parser and output stage
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_EDIT_MODE      = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IGNORE_PICTURE = 1'd1;

  // Edit modes (anything else is an "other" edit mode)
  localparam logic [MODE_W-1:0] MODE_LIST  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;

  // Routes
  localparam logic [ROUTE_W-1:0] ROUTE_DROP    = 2'd0;
  localparam logic [ROUTE_W-1:0] ROUTE_STREAM  = 2'd1;
  localparam logic [ROUTE_W-1:0] ROUTE_COMMENT = 2'd2;
  localparam logic [ROUTE_W-1:0] ROUTE_PICTURE = 2'd3;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NOT_FLAC = 2'd1;
  localparam logic [ERR_W-1:0] ERR_BAD_META = 2'd2;

  // Metadata block types
  localparam logic [TYPE_W-1:0] TYPE_STREAMINFO = 7'd0;
  localparam logic [TYPE_W-1:0] TYPE_PADDING    = 7'd1;
  localparam logic [TYPE_W-1:0] TYPE_COMMENT    = 7'd4;
  localparam logic [TYPE_W-1:0] TYPE_PICTURE    = 7'd6;
  localparam logic [TYPE_W-1:0] TYPE_INVALID    = 7'd127;

  // Required STREAMINFO payload length
  localparam logic [LEN_W-1:0] STREAMINFO_LEN = 24'd34;

  // One result item
  typedef struct packed {
    logic [ERR_W-1:0]   error_code;
    logic               metadata_done;
    logic               block_end;
    logic [TYPE_W-1:0]  block_type;
    logic [ROUTE_W-1:0] route;
    logic [BYTE_W-1:0]  out_byte;
  } result_t;

  // Stream magic "fLaC", one byte per position
  function automatic logic [BYTE_W-1:0] magic_byte(input logic [1:0] pos);
    logic [BYTE_W-1:0] m;
    case (pos)
      2'd0:    m = 8'h66;
      2'd1:    m = 8'h4C;
      2'd2:    m = 8'h61;
      2'd3:    m = 8'h43;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/fmbf_front.sv -----
// Front end: configuration registers and the byte-serial metadata walker.
`default_nettype none
module fmbf_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [fmbf_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  wire logic [fmbf_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  wire logic                                  in_valid,
  input  wire logic [fmbf_pkg::BYTE_W-1:0]           in_data,
  output      logic                                  in_ready,
  input  wire logic                                  q_full,
  output      logic                                  push,
  output      fmbf_pkg::result_t                     res
);

  typedef enum logic [3:0] {
    PH_MAGIC   = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_AUDIO   = 4'b1000
  } phase_t;

  // Payload route picked on header byte zero
  function automatic logic [fmbf_pkg::ROUTE_W-1:0] choose_route(
    input logic [fmbf_pkg::TYPE_W-1:0] t,
    input logic [fmbf_pkg::MODE_W-1:0] mode,
    input logic                        ign
  );
    logic [fmbf_pkg::ROUTE_W-1:0] r;
    if (t == fmbf_pkg::TYPE_COMMENT) begin
      r = fmbf_pkg::ROUTE_COMMENT;
    end else if (t == fmbf_pkg::TYPE_PADDING) begin
      r = fmbf_pkg::ROUTE_DROP;
    end else if (t == fmbf_pkg::TYPE_PICTURE) begin
      if (mode == fmbf_pkg::MODE_LIST) begin
        r = ign ? fmbf_pkg::ROUTE_DROP : fmbf_pkg::ROUTE_PICTURE;
      end else if (mode == fmbf_pkg::MODE_WRITE) begin
        r = ign ? fmbf_pkg::ROUTE_STREAM : fmbf_pkg::ROUTE_DROP;
      end else begin
        r = fmbf_pkg::ROUTE_STREAM;
      end
    end else begin
      r = (mode == fmbf_pkg::MODE_LIST) ? fmbf_pkg::ROUTE_DROP : fmbf_pkg::ROUTE_STREAM;
    end
    return r;
  endfunction

  logic [fmbf_pkg::MODE_W-1:0]  edit_mode_r;
  logic                         ign_pic_r;

  phase_t                       phase_r, phase_nxt;
  logic [1:0]                   pos_r, pos_nxt;
  logic [fmbf_pkg::LEN_W-1:0]   rem_r, rem_nxt;
  logic [fmbf_pkg::TYPE_W-1:0]  type_r, type_nxt;
  logic                         last_r, last_nxt;
  logic                         any_seen_r, any_seen_nxt;
  logic                         cmt_seen_r, cmt_seen_nxt;
  logic [fmbf_pkg::ROUTE_W-1:0] route_r, route_nxt;
  logic [fmbf_pkg::ERR_W-1:0]   err_r, err_nxt;

  logic [fmbf_pkg::ERR_W-1:0]   err;
  logic [fmbf_pkg::TYPE_W-1:0]  hdr_type;
  logic [fmbf_pkg::LEN_W-1:0]   rem_shift;
  logic [fmbf_pkg::LEN_W-1:0]   rem_dec;
  logic                         finish;
  logic                         accept;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign push      = accept;
  assign hdr_type  = in_data[fmbf_pkg::TYPE_W-1:0];
  assign rem_shift = {rem_r[fmbf_pkg::LEN_W-fmbf_pkg::BYTE_W-1:0], in_data};
  assign rem_dec   = rem_r - fmbf_pkg::LEN_W'(1);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edit_mode_r <= fmbf_pkg::MODE_LIST;
      ign_pic_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        fmbf_pkg::CFG_EDIT_MODE:      edit_mode_r <= cfg_wdata;
        fmbf_pkg::CFG_IGNORE_PICTURE: ign_pic_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Walker: result and next state for the byte on the input
  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    rem_nxt      = rem_r;
    type_nxt     = type_r;
    last_nxt     = last_r;
    any_seen_nxt = any_seen_r;
    cmt_seen_nxt = cmt_seen_r;
    route_nxt    = route_r;
    err_nxt      = err_r;
    err          = fmbf_pkg::ERR_NONE;
    finish       = 1'b0;
    res          = '0;
    res.out_byte = in_data;

    if (err_r != fmbf_pkg::ERR_NONE) begin
      res.error_code = err_r;
    end else begin
      case (phase_r)
        PH_MAGIC: begin
          if (in_data != fmbf_pkg::magic_byte(pos_r)) begin
            err = fmbf_pkg::ERR_NOT_FLAC;
          end else begin
            res.route = fmbf_pkg::ROUTE_STREAM;
            pos_nxt   = 2'(pos_r + 2'd1);
            if (pos_r == 2'd3) begin
              phase_nxt = PH_HEADER;
            end
          end
        end
        PH_HEADER: begin
          if (pos_r == 2'd0) begin
            if ((hdr_type == fmbf_pkg::TYPE_STREAMINFO && any_seen_r) ||
                hdr_type == fmbf_pkg::TYPE_INVALID ||
                (cmt_seen_r && hdr_type == fmbf_pkg::TYPE_COMMENT)) begin
              err = fmbf_pkg::ERR_BAD_META;
            end else begin
              type_nxt     = hdr_type;
              last_nxt     = in_data[fmbf_pkg::BYTE_W-1];
              any_seen_nxt = 1'b1;
              if (hdr_type == fmbf_pkg::TYPE_COMMENT) begin
                cmt_seen_nxt = 1'b1;
              end
              route_nxt      = choose_route(hdr_type, edit_mode_r, ign_pic_r);
              rem_nxt        = '0;
              res.out_byte   = {1'b0, hdr_type};
              res.route      = (route_nxt == fmbf_pkg::ROUTE_STREAM) ?
                               fmbf_pkg::ROUTE_STREAM : fmbf_pkg::ROUTE_DROP;
              res.block_type = hdr_type;
              pos_nxt        = 2'd1;
            end
          end else begin
            rem_nxt = rem_shift;
            if (pos_r == 2'd3 && type_r == fmbf_pkg::TYPE_STREAMINFO &&
                rem_shift != fmbf_pkg::STREAMINFO_LEN) begin
              err = fmbf_pkg::ERR_BAD_META;
            end else begin
              res.route      = (route_r == fmbf_pkg::ROUTE_STREAM) ?
                               fmbf_pkg::ROUTE_STREAM : fmbf_pkg::ROUTE_DROP;
              res.block_type = type_r;
              pos_nxt        = 2'(pos_r + 2'd1);
              if (pos_r == 2'd3) begin
                if (rem_shift == '0) begin
                  finish = 1'b1;
                end else begin
                  phase_nxt = PH_PAYLOAD;
                end
              end
            end
          end
        end
        PH_PAYLOAD: begin
          res.route      = route_r;
          res.block_type = type_r;
          rem_nxt        = rem_dec;
          if (rem_dec == '0) begin
            finish = 1'b1;
          end
        end
        default: begin
          res.route = (edit_mode_r == fmbf_pkg::MODE_LIST) ?
                      fmbf_pkg::ROUTE_DROP : fmbf_pkg::ROUTE_STREAM;
        end
      endcase

      // End of a metadata block
      if (finish) begin
        res.block_end     = 1'b1;
        res.metadata_done = last_r;
        phase_nxt         = last_r ? PH_AUDIO : PH_HEADER;
        pos_nxt           = 2'd0;
      end

      // A new error blanks the result and sticks
      if (err != fmbf_pkg::ERR_NONE) begin
        res            = '0;
        res.out_byte   = in_data;
        res.error_code = err;
        err_nxt        = err;
      end
    end
  end

  // Walker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_MAGIC;
      pos_r      <= 2'd0;
      rem_r      <= '0;
      type_r     <= '0;
      last_r     <= 1'b0;
      any_seen_r <= 1'b0;
      cmt_seen_r <= 1'b0;
      route_r    <= fmbf_pkg::ROUTE_DROP;
      err_r      <= fmbf_pkg::ERR_NONE;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      rem_r      <= rem_nxt;
      type_r     <= type_nxt;
      last_r     <= last_nxt;
      any_seen_r <= any_seen_nxt;
      cmt_seen_r <= cmt_seen_nxt;
      route_r    <= route_nxt;
      err_r      <= err_nxt;
    end
  end

`ifndef SYNTHESIS
  // Once set, the error holds until reset
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != fmbf_pkg::ERR_NONE |=> err_r == $past(err_r))
    else $error("sticky error changed");

  // An erroring result carries no route or block type
  a_err_blank: assert property (@(posedge clk) disable iff (!rst_n)
    push && res.error_code != fmbf_pkg::ERR_NONE |->
      res.route == fmbf_pkg::ROUTE_DROP && res.block_type == '0)
    else $error("error result not blanked");

  // Metadata end only comes on a block end
  a_done_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    push && res.metadata_done |-> res.block_end)
    else $error("metadata_done without block_end");
`endif

endmodule
`default_nettype wire

// ----- hdl/fmbf_queue.sv -----
// Short result queue between the walker and the output stage.
`default_nettype none
module fmbf_queue #(
  parameter int unsigned DEPTH = fmbf_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire fmbf_pkg::result_t push_data,
  input  wire logic              pop,
  output      logic              full,
  output      logic              not_empty,
  output      fmbf_pkg::result_t head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  fmbf_pkg::result_t slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_SLOT) ? '0 : AW'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_SLOT) ? '0 : AW'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        count_r <= CW'(count_r + 1'b1);
      end else if (pop && !push) begin
        count_r <= CW'(count_r - 1'b1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !not_empty))
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// ----- hdl/fmbf_back.sv -----
// Back end: output register that drives the result channel.
`default_nettype none
module fmbf_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_valid,
  input  wire fmbf_pkg::result_t               q_head,
  output      logic                            q_pop,
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  output      logic [fmbf_pkg::BYTE_W-1:0]     out_tdata,
  output      logic [fmbf_pkg::TUSER_W-1:0]    out_tuser,
  output      logic                            out_tlast
);

  logic              valid_r;
  fmbf_pkg::result_t data_r;

  // Refill whenever the register is empty or being drained
  assign q_pop = q_valid && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= q_head;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r.out_byte;
  assign out_tlast  = data_r.block_end;
  assign out_tuser  = {4'd0, data_r.error_code, data_r.metadata_done,
                       data_r.block_type, data_r.route};

endmodule
`default_nettype wire

// ----- hdl/flac_metadata_block_filter_unit.sv -----
// Top level of the FLAC metadata block filter: walker, queue and output stage.
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+-------------------------------------------
//  in_     | in  | in_tvalid / in_tready    | in_tdata: raw stream byte
//  out_    | out | out_tvalid / out_tready  | out_tdata byte, out_tuser, out_tlast
//  cfg_    | in  | cfg_we                   | cfg_addr, cfg_wdata
//
// One byte per cycle sustained while out_tready is high; out_tvalid is registered.
// The walker updates its state in the cycle a byte transfers; a four-entry queue and the
// output register hold results while out_tready is low, and in_tready drops once it fills.
// rst_n is synchronous: it clears walker state, configuration and the queue, no clearing pass.
`default_nettype none
module flac_metadata_block_filter_unit #(
  parameter int unsigned QUEUE_DEPTH = fmbf_pkg::QUEUE_DEPTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [fmbf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [fmbf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  input  wire logic [fmbf_pkg::BYTE_W-1:0]        in_tdata,   // [7:0] data_byte
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  output      logic [fmbf_pkg::BYTE_W-1:0]        out_tdata,  // [7:0] out_byte
  // [1:0] route, [8:2] block_type, [9] metadata_done, [11:10] error_code, [15:12] zero
  output      logic [fmbf_pkg::TUSER_W-1:0]       out_tuser,
  output      logic                               out_tlast   // block_end
);

  fmbf_pkg::result_t res, q_head;
  logic push, q_full, q_valid, q_pop;

  fmbf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_data   (in_tdata),
    .in_ready  (in_tready),
    .q_full    (q_full),
    .push      (push),
    .res       (res)
  );

  fmbf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  fmbf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ----- dv/flac_metadata_block_filter_unit_tb.sv -----
// Self-checking testbench for the FLAC metadata block filter: byte stimulus, predictor, checker.
`timescale 1ns / 1ps
module flac_metadata_block_filter_unit_tb;

  // Extra block types and an edit mode used by the stimulus
  localparam logic [fmbf_pkg::TYPE_W-1:0] TYPE_APPLICATION = 7'd2;
  localparam logic [fmbf_pkg::TYPE_W-1:0] TYPE_SEEKTABLE   = 7'd3;
  localparam logic [fmbf_pkg::TYPE_W-1:0] TYPE_CUESHEET    = 7'd5;
  localparam logic [fmbf_pkg::TYPE_W-1:0] TYPE_FIRST_SPARE = 7'd7;
  localparam logic [fmbf_pkg::TYPE_W-1:0] TYPE_LAST_SPARE  = 7'd126;
  localparam logic [fmbf_pkg::MODE_W-1:0] MODE_OTHER_ALT   = 2'd3;

  localparam logic [31:0] FLAC_TAG    = 32'h664C6143;
  localparam int unsigned WALK_ITEMS  = 270;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef enum logic [1:0] {WALK_MAGIC, WALK_HEADER, WALK_PAYLOAD, WALK_AUDIO} walk_phase_t;
  typedef enum int {
    FAULT_MAGIC, FAULT_STREAMINFO_LEN, FAULT_INVALID_TYPE, FAULT_SECOND_COMMENT,
    FAULT_LATE_STREAMINFO, FAULT_NONE
  } fault_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [fmbf_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [fmbf_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [fmbf_pkg::BYTE_W-1:0]     in_tdata;   // [7:0] data_byte
  logic                            out_tvalid;
  logic                            out_tready;
  logic [fmbf_pkg::BYTE_W-1:0]     out_tdata;  // [7:0] out_byte
  // [1:0] route, [8:2] block_type, [9] metadata_done, [11:10] error_code
  logic [fmbf_pkg::TUSER_W-1:0]    out_tuser;
  logic                            out_tlast;  // block_end

  flac_metadata_block_filter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Predictor state and configuration copy
  walk_phase_t                  walk_phase   = WALK_MAGIC;
  logic [1:0]                   hdr_pos      = '0;
  logic [fmbf_pkg::LEN_W-1:0]   blk_len_left = '0;
  logic [fmbf_pkg::TYPE_W-1:0]  blk_type_q   = '0;
  logic                         blk_last_q   = 1'b0;
  logic                         seen_block   = 1'b0;
  logic                         seen_comment = 1'b0;
  logic [fmbf_pkg::ROUTE_W-1:0] blk_route    = fmbf_pkg::ROUTE_DROP;
  logic [fmbf_pkg::ERR_W-1:0]   err_sticky   = fmbf_pkg::ERR_NONE;
  logic [fmbf_pkg::MODE_W-1:0]  mode_q       = fmbf_pkg::MODE_LIST;
  logic                         ign_pic_q    = 1'b0;

  fmbf_pkg::result_t routed_q[$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent = 0;
  bit          src_quiet = 1'b0;
  bit          sink_quiet = 1'b0;
  bit          hold_req = 1'b0;
  bit          comment_sent = 1'b0;
  fault_t      fault;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Block finished: move to audio after the flagged block, else to the next header
  function automatic logic close_block();
    walk_phase = blk_last_q ? WALK_AUDIO : WALK_HEADER;
    hdr_pos = 2'd0;
    return blk_last_q;
  endfunction

  // Expected routing of one stream byte; advances the walker state
  function automatic fmbf_pkg::result_t route_byte(input logic [fmbf_pkg::BYTE_W-1:0] b);
    fmbf_pkg::result_t           r;
    logic [fmbf_pkg::TYPE_W-1:0] t;
    logic [fmbf_pkg::ERR_W-1:0]  err;
    r = '0;
    r.out_byte = b;
    err = fmbf_pkg::ERR_NONE;
    if (err_sticky != fmbf_pkg::ERR_NONE) begin
      r.error_code = err_sticky;
      return r;
    end
    case (walk_phase)
      WALK_MAGIC: begin
        if (b != FLAC_TAG[8*(3-hdr_pos) +: 8]) begin
          err = fmbf_pkg::ERR_NOT_FLAC;
        end else begin
          r.route = fmbf_pkg::ROUTE_STREAM;
          if (hdr_pos == 2'd3) walk_phase = WALK_HEADER;
          hdr_pos = hdr_pos + 2'd1;
        end
      end
      WALK_HEADER: begin
        if (hdr_pos == 2'd0) begin
          t = b[6:0];
          if ((t == fmbf_pkg::TYPE_STREAMINFO && seen_block) || t == fmbf_pkg::TYPE_INVALID ||
              (seen_comment && t == fmbf_pkg::TYPE_COMMENT)) begin
            err = fmbf_pkg::ERR_BAD_META;
          end else begin
            blk_type_q = t;
            blk_last_q = b[7];
            seen_block = 1'b1;
            if (t == fmbf_pkg::TYPE_COMMENT) seen_comment = 1'b1;
            // routing of the whole block is fixed here
            if (t == fmbf_pkg::TYPE_COMMENT) blk_route = fmbf_pkg::ROUTE_COMMENT;
            else if (t == fmbf_pkg::TYPE_PADDING) blk_route = fmbf_pkg::ROUTE_DROP;
            else if (t == fmbf_pkg::TYPE_PICTURE) begin
              if (mode_q == fmbf_pkg::MODE_LIST)
                blk_route = ign_pic_q ? fmbf_pkg::ROUTE_DROP : fmbf_pkg::ROUTE_PICTURE;
              else if (mode_q == fmbf_pkg::MODE_WRITE)
                blk_route = ign_pic_q ? fmbf_pkg::ROUTE_STREAM : fmbf_pkg::ROUTE_DROP;
              else blk_route = fmbf_pkg::ROUTE_STREAM;
            end else begin
              blk_route = (mode_q == fmbf_pkg::MODE_LIST) ?
                          fmbf_pkg::ROUTE_DROP : fmbf_pkg::ROUTE_STREAM;
            end
            blk_len_left = '0;
            r.out_byte = {1'b0, t};
            r.route = (blk_route == fmbf_pkg::ROUTE_STREAM) ?
                      fmbf_pkg::ROUTE_STREAM : fmbf_pkg::ROUTE_DROP;
            r.block_type = t;
            hdr_pos = 2'd1;
          end
        end else begin
          blk_len_left = {blk_len_left[15:0], b};
          if (hdr_pos == 2'd3 && blk_type_q == fmbf_pkg::TYPE_STREAMINFO &&
              blk_len_left != fmbf_pkg::STREAMINFO_LEN) begin
            err = fmbf_pkg::ERR_BAD_META;
          end else begin
            r.route = (blk_route == fmbf_pkg::ROUTE_STREAM) ?
                      fmbf_pkg::ROUTE_STREAM : fmbf_pkg::ROUTE_DROP;
            r.block_type = blk_type_q;
            if (hdr_pos == 2'd3) begin
              hdr_pos = 2'd0;
              if (blk_len_left == '0) begin
                r.block_end = 1'b1;
                r.metadata_done = close_block();
              end else begin
                walk_phase = WALK_PAYLOAD;
              end
            end else begin
              hdr_pos = hdr_pos + 2'd1;
            end
          end
        end
      end
      WALK_PAYLOAD: begin
        r.route = blk_route;
        r.block_type = blk_type_q;
        blk_len_left = blk_len_left - 1'b1;
        if (blk_len_left == '0) begin
          r.block_end = 1'b1;
          r.metadata_done = close_block();
        end
      end
      default: begin
        r.route = (mode_q == fmbf_pkg::MODE_LIST) ? fmbf_pkg::ROUTE_DROP : fmbf_pkg::ROUTE_STREAM;
      end
    endcase
    if (err != fmbf_pkg::ERR_NONE) begin
      err_sticky = err;
      r = '0;
      r.out_byte = b;
      r.error_code = err;
    end
    return r;
  endfunction

  // Idle cycles before one transfer; zero in quiet stretches
  function automatic int unsigned draw_wait(input bit quiet);
    if (quiet || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(1, 16);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Send one byte; in_tvalid stays high after the transfer unless a gap follows
  task automatic send_byte(input logic [fmbf_pkg::BYTE_W-1:0] b);
    int unsigned gap;
    gap = draw_wait(src_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    routed_q.push_back(route_byte(b));
    bytes_sent++;
  endtask

  // Stop sending and wait until every routed byte has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (routed_q.size() != 0);
  endtask

  task automatic write_reg(input logic [fmbf_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [fmbf_pkg::CFG_DATA_W-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == fmbf_pkg::CFG_EDIT_MODE) mode_q = val;
    else ign_pic_q = val[0];
  endtask

  task automatic shuffle_config();
    case ($urandom_range(0, 2))
      0: write_reg(fmbf_pkg::CFG_EDIT_MODE, 2'($urandom_range(0, 3)));
      1: write_reg(fmbf_pkg::CFG_IGNORE_PICTURE, 2'($urandom_range(0, 3)));
      default: begin
        write_reg(fmbf_pkg::CFG_EDIT_MODE, 2'($urandom_range(0, 3)));
        write_reg(fmbf_pkg::CFG_IGNORE_PICTURE, 2'($urandom_range(0, 3)));
      end
    endcase
  endtask

  // Header plus random payload; optional config change before payload byte cfg_at
  task automatic send_block(input logic last, input logic [fmbf_pkg::TYPE_W-1:0] btype,
                            input int unsigned len, input bit with_payload = 1'b1,
                            input int cfg_at = -1);
    logic [fmbf_pkg::LEN_W-1:0] l;
    l = fmbf_pkg::LEN_W'(len);
    if (btype == fmbf_pkg::TYPE_COMMENT) comment_sent = 1'b1;
    send_byte({last, btype});
    send_byte(l[23:16]);
    send_byte(l[15:8]);
    send_byte(l[7:0]);
    if (with_payload) begin
      for (int i = 0; i < int'(len); i++) begin
        if (i == cfg_at) shuffle_config();
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  function automatic logic [fmbf_pkg::TYPE_W-1:0] random_block_type();
    case ($urandom_range(0, 9))
      0, 1:    return fmbf_pkg::TYPE_PICTURE;
      2:       return fmbf_pkg::TYPE_PADDING;
      3:       return comment_sent ? TYPE_APPLICATION : fmbf_pkg::TYPE_COMMENT;
      4:       return TYPE_APPLICATION;
      5:       return TYPE_SEEKTABLE;
      6:       return TYPE_CUESHEET;
      default: return fmbf_pkg::TYPE_W'($urandom_range(TYPE_FIRST_SPARE, TYPE_LAST_SPARE));
    endcase
  endfunction

  // Mostly short payloads, a few past 256 so the middle length byte is used
  function automatic int unsigned random_len();
    case ($urandom_range(0, 15))
      0, 1:    return 0;
      15:      return $urandom_range(250, 280);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // Magic word, with one corrupted byte when a magic fault is chosen
  task automatic test_magic();
    int unsigned bad_pos;
    logic [fmbf_pkg::BYTE_W-1:0] b;
    bad_pos = (fault == FAULT_MAGIC) ? $urandom_range(0, 3) : 4;
    for (int i = 0; i < 4; i++) begin
      b = FLAC_TAG[8*(3-i) +: 8];
      if (i == bad_pos) b = b ^ 8'($urandom_range(1, 255));
      send_byte(b);
    end
  endtask

  // STREAMINFO first; a wrong length errors on the last header byte
  task automatic test_streaminfo();
    logic [fmbf_pkg::LEN_W-1:0] len;
    len = fmbf_pkg::STREAMINFO_LEN;
    if (fault == FAULT_STREAMINFO_LEN) begin
      do len = fmbf_pkg::LEN_W'($urandom); while (len == fmbf_pkg::STREAMINFO_LEN);
      send_block(1'b0, fmbf_pkg::TYPE_STREAMINFO, len, 1'b0);
    end else begin
      send_block(1'b0, fmbf_pkg::TYPE_STREAMINFO, len);
    end
  endtask

  // Routing of picture, padding, comment and other block types across edit modes and picture settings
  task automatic test_block_routes();
    write_reg(fmbf_pkg::CFG_EDIT_MODE, fmbf_pkg::MODE_LIST);
    write_reg(fmbf_pkg::CFG_IGNORE_PICTURE, 2'd0);
    if ($urandom_range(0, 1) != 0) send_block(1'b0, fmbf_pkg::TYPE_COMMENT, 2);
    send_block(1'b0, fmbf_pkg::TYPE_PICTURE, 1);
    send_block(1'b0, fmbf_pkg::TYPE_PADDING, 0);
    send_block(1'b0, TYPE_LAST_SPARE, 1);
    write_reg(fmbf_pkg::CFG_IGNORE_PICTURE, 2'd1);
    send_block(1'b0, fmbf_pkg::TYPE_PICTURE, 0);
    write_reg(fmbf_pkg::CFG_EDIT_MODE, fmbf_pkg::MODE_WRITE);
    send_block(1'b0, fmbf_pkg::TYPE_PICTURE, 0);
    write_reg(fmbf_pkg::CFG_IGNORE_PICTURE, 2'd0);
    send_block(1'b0, fmbf_pkg::TYPE_PICTURE, 1);
    write_reg(fmbf_pkg::CFG_EDIT_MODE, MODE_OTHER_ALT);
    send_block(1'b0, fmbf_pkg::TYPE_PICTURE, 0);
    send_block(1'b0, TYPE_APPLICATION, 1);
  endtask

  // Receiver holds off while the sender streams a payload at full rate
  task automatic test_backpressure();
    src_quiet = 1'b1;
    hold_req = 1'b1;
    send_block(1'b0, TYPE_APPLICATION, 48);
    src_quiet = 1'b0;
  endtask

  // Well-formed blocks with random types, lengths, idling and config changes
  task automatic test_random_walk();
    int unsigned start;
    int unsigned len;
    int cfg_at;
    start = bytes_sent;
    while (bytes_sent - start < WALK_ITEMS) begin
      src_quiet = ($urandom_range(0, 4) == 0);
      sink_quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0) shuffle_config();
      len = random_len();
      cfg_at = -1;
      if (len > 0 && $urandom_range(0, 3) == 0) cfg_at = int'($urandom_range(0, len - 1));
      send_block(1'b0, random_block_type(), len, 1'b1, cfg_at);
    end
    src_quiet = 1'b0;
    sink_quiet = 1'b0;
  endtask

  // Close the metadata with a last block and audio, or with a bad header
  task automatic test_stream_end();
    int unsigned k;
    case (fault)
      FAULT_INVALID_TYPE: send_byte({1'($urandom_range(0, 1)), fmbf_pkg::TYPE_INVALID});
      FAULT_SECOND_COMMENT: begin
        if (!comment_sent) send_block(1'b0, fmbf_pkg::TYPE_COMMENT, $urandom_range(0, 6));
        send_byte({1'($urandom_range(0, 1)), fmbf_pkg::TYPE_COMMENT});
      end
      FAULT_LATE_STREAMINFO: send_byte({1'($urandom_range(0, 1)), fmbf_pkg::TYPE_STREAMINFO});
      default: begin
        send_block(1'b1, random_block_type(), random_len());
        // audio routing follows the edit mode byte by byte
        k = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++) begin
          write_reg(fmbf_pkg::CFG_EDIT_MODE, 2'(i) ^ 2'(k));
          repeat (16) send_byte(8'($urandom_range(0, 255)));
        end
      end
    endcase
    repeat (30) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Result receiver: random stalls per transfer, one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    int unsigned hold;
    stall = 0;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (out_tvalid && out_tready) stall = draw_wait(sink_quiet);
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest routed byte
  always @(posedge clk) begin : result_check
    fmbf_pkg::result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (routed_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual tdata %0h tuser %0h tlast %0b",
                 $time, out_tdata, out_tuser, out_tlast);
        mismatch_count++;
      end else begin
        exp_r = routed_q.pop_front();
        check_field("out_byte", exp_r.out_byte, out_tdata);
        check_field("route", 8'(exp_r.route), 8'(out_tuser[1:0]));
        check_field("block_type", 8'(exp_r.block_type), 8'(out_tuser[8:2]));
        check_field("metadata_done", 8'(exp_r.metadata_done), 8'(out_tuser[9]));
        check_field("error_code", 8'(exp_r.error_code), 8'(out_tuser[11:10]));
        check_field("block_end", 8'(exp_r.block_end), 8'(out_tlast));
      end
    end
  end

  // Cycle limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Main sequence
  initial begin : main_flow
    int unsigned k;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    k = $urandom_range(0, 9);
    fault = (k > 4) ? FAULT_NONE : fault_t'(k);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(fmbf_pkg::CFG_EDIT_MODE, 2'($urandom_range(0, 3)));
    write_reg(fmbf_pkg::CFG_IGNORE_PICTURE, 2'($urandom_range(0, 1)));
    test_magic();
    test_streaminfo();
    test_block_routes();
    test_backpressure();
    test_random_walk();
    test_stream_end();
    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/fmbf_pkg.sv
hdl/fmbf_front.sv
hdl/fmbf_queue.sv
hdl/fmbf_back.sv
hdl/flac_metadata_block_filter_unit.sv
dv/flac_metadata_block_filter_unit_tb.sv
